// ===== sv/pctd_pkg.sv =====
// ============================================================================
// Percent decoder package
// Shared types, character constants and hex helpers for the percent decoder.
// ============================================================================
`default_nettype none

package pctd_pkg;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

    typedef enum logic [2:0] {
        PEND_NONE = 3'b001,
        PEND_PCT  = 3'b010,
        PEND_HEX  = 3'b100
    } pend_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] cnt;
        logic       eos;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CHAR_0) && (c <= CHAR_9)) ||
               ((c >= CHAR_UC_A) && (c <= CHAR_UC_F)) ||
               ((c >= CHAR_LC_A) && (c <= CHAR_LC_F));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= CHAR_9)
        begin
            return c[3:0];
        end
        return c[3:0] + HEX_LETTER_OFS;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pctd_front.sv =====
// ============================================================================
// Percent decoder front end
// Accepts input bytes, tracks pending escapes and issues output commands.
// ============================================================================
`default_nettype none

module pctd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_eos,
    input  wire logic            q_full,
    output logic                 in_ready,
    output logic                 push,
    output pctd_pkg::cmd_t       cmd,
    output logic                 idle
);

    pctd_pkg::pend_t state_reg, state_next;
    logic [7:0]      fhc_reg, fhc_next;
    logic            accept;
    logic            b_hex;
    logic            b_pct_open;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign b_hex      = pctd_pkg::is_hex(in_byte);
    assign b_pct_open = (in_byte == pctd_pkg::CHAR_PCT) && !in_eos;
    assign idle       = (state_reg == pctd_pkg::PEND_NONE);

    always_comb
    begin
        state_next = state_reg;
        fhc_next   = fhc_reg;
        cmd        = '0;
        cmd.eos    = in_eos;
        case (state_reg)
            pctd_pkg::PEND_NONE:
            begin
                if (b_pct_open)
                begin
                    state_next = pctd_pkg::PEND_PCT;
                end
                else
                begin
                    cmd.cnt   = 2'd1;
                    cmd.byte0 = in_byte;
                end
            end
            pctd_pkg::PEND_PCT:
            begin
                cmd.byte0 = pctd_pkg::CHAR_PCT;
                if (b_hex)
                begin
                    if (in_eos)
                    begin
                        cmd.cnt    = 2'd2;
                        cmd.byte1  = in_byte;
                        state_next = pctd_pkg::PEND_NONE;
                    end
                    else
                    begin
                        state_next = pctd_pkg::PEND_HEX;
                        fhc_next   = in_byte;
                    end
                end
                else if (b_pct_open)
                begin
                    cmd.cnt    = 2'd1;
                    state_next = pctd_pkg::PEND_PCT;
                end
                else
                begin
                    cmd.cnt    = 2'd2;
                    cmd.byte1  = in_byte;
                    state_next = pctd_pkg::PEND_NONE;
                end
            end
            pctd_pkg::PEND_HEX:
            begin
                if (b_hex)
                begin
                    cmd.cnt    = 2'd1;
                    cmd.byte0  = {pctd_pkg::hex_nibble(fhc_reg), pctd_pkg::hex_nibble(in_byte)};
                    state_next = pctd_pkg::PEND_NONE;
                end
                else
                begin
                    cmd.byte0 = pctd_pkg::CHAR_PCT;
                    cmd.byte1 = fhc_reg;
                    if (b_pct_open)
                    begin
                        cmd.cnt    = 2'd2;
                        state_next = pctd_pkg::PEND_PCT;
                    end
                    else
                    begin
                        cmd.cnt    = 2'd3;
                        cmd.byte2  = in_byte;
                        state_next = pctd_pkg::PEND_NONE;
                    end
                end
            end
            default:
            begin
                state_next = pctd_pkg::PEND_NONE;
            end
        endcase
    end

    assign push = accept && (cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pctd_pkg::PEND_NONE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fhc_reg <= fhc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pctd_queue.sv =====
// ============================================================================
// Percent decoder command queue
// Small register FIFO that decouples the front end from the output side.
// ============================================================================
`default_nettype none

module pctd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pctd_pkg::cmd_t   push_cmd,
    input  wire logic             pop,
    output pctd_pkg::cmd_t        head,
    output pctd_pkg::q_stat_t     stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pctd_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/pctd_back.sv =====
// ============================================================================
// Percent decoder back end
// Expands each queued command into one to three output transactions.
// ============================================================================
`default_nettype none

module pctd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pctd_pkg::cmd_t     head,
    input  wire pctd_pkg::q_stat_t  stat,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [7:0]              out_byte,
    output logic                    run_last,
    output logic                    string_end,
    output logic                    pop
);

    logic [1:0] beat_reg, beat_next;
    logic       fire;

    assign out_valid  = !stat.empty;
    assign fire       = out_valid && out_ready;
    assign run_last   = (beat_reg == (head.cnt - 2'd1));
    assign string_end = run_last && head.eos;
    assign pop        = fire && run_last;

    always_comb
    begin
        case (beat_reg)
            2'd0:    out_byte = head.byte0;
            2'd1:    out_byte = head.byte1;
            2'd2:    out_byte = head.byte2;
            default: out_byte = head.byte0;
        endcase
    end

    always_comb
    begin
        beat_next = beat_reg;
        if (pop)
        begin
            beat_next = 2'd0;
        end
        else if (fire)
        begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= 2'd0;
        end
        else
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/percent_decoder_unit.sv =====
// ============================================================================
// Percent decoder unit
// Streaming URL percent-escape decoder with a decoupled command queue.
// ============================================================================
//  Channel  Dir  Handshake         Content
//  s_*      in   s_tvalid/tready   tdata = in_byte, tlast = end_of_string
//  m_*      out  m_tvalid/tready   tdata = out_byte, tuser = run_last,
//                                  tlast = string_end
//
//  An input transaction is taken back to back while the queue has room. Each
//  input produces zero to three output transactions, one per cycle while
//  m_tready is high, drained by the back end from the head of the queue.
//  Reset clears the pending-escape state, the queue pointers and the beat count.
//  A stalled output fills the queue of QUEUE_DEPTH commands before s_tready drops.
`default_nettype none

module percent_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tuser,   // [0] run_last
    output logic             m_tlast
);

    pctd_pkg::cmd_t    push_cmd;
    pctd_pkg::cmd_t    head;
    pctd_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;
    logic              front_idle;

    pctd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_eos   (s_tlast),
        .q_full   (q_stat.full),
        .in_ready (s_tready),
        .push     (push),
        .cmd      (push_cmd),
        .idle     (front_idle)
    );

    pctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    pctd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .stat       (q_stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (m_tdata),
        .run_last   (m_tuser),
        .string_end (m_tlast),
        .pop        (pop)
    );

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("Command pushed into a full queue.");

    a_stat_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("Queue reports full and empty at once.");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("String end on a transaction that is not the last of its input.");

    a_eos_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> front_idle)
        else $error("Front end still holds an escape after end of string.");
`endif

endmodule

`default_nettype wire

// ===== verif/percent_decoder_unit_tb.sv =====
// ============================================================================
// Percent decoder unit testbench
// Streams encoded strings into the decoder and checks every decoded byte,
// run_last and string_end against a cycle-free predictor of the escape rules.
// A short directed part covers broken escapes and end-of-string flushes, then
// random strings follow, built mostly from valid escapes. Both stream sides
// idle at random, apart from one stretch with no idling at all.
// ============================================================================
`default_nettype none

module percent_decoder_unit_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 480;
    localparam int IDLE_PCT     = 27;
    localparam int SETTLE_WAIT  = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STEADY_FIRST = 200;
    localparam int STEADY_LAST  = 320;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } raw_item_t;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } decoded_beat_t;

    class decode_scoreboard;
        pctd_pkg::pend_t pend;
        logic [7:0]      held_digit;
        logic [7:0]      step_bytes[$];
        decoded_beat_t   expected_q[$];
        int              errors;
        int              inputs_seen;
        int              strings_seen;
        int              beats_checked;
        int              escapes_decoded;

        function new();
            pend = pctd_pkg::PEND_NONE;
            held_digit = '0;
            errors = 0;
            inputs_seen = 0;
            strings_seen = 0;
            beats_checked = 0;
            escapes_decoded = 0;
        endfunction

        // Bit 4 flags a hex digit, bits 3:0 hold its value.
        function logic [4:0] hex_digit(logic [7:0] c);
            if (c >= pctd_pkg::CHAR_0 && c <= pctd_pkg::CHAR_9)
            begin
                return {1'b1, 4'(c - pctd_pkg::CHAR_0)};
            end
            if (c >= pctd_pkg::CHAR_UC_A && c <= pctd_pkg::CHAR_UC_F)
            begin
                return {1'b1, 4'(c - pctd_pkg::CHAR_UC_A + 8'd10)};
            end
            if (c >= pctd_pkg::CHAR_LC_A && c <= pctd_pkg::CHAR_LC_F)
            begin
                return {1'b1, 4'(c - pctd_pkg::CHAR_LC_A + 8'd10)};
            end
            return 5'd0;
        endfunction

        function void take_plain(logic [7:0] b, logic eos);
            if (b == pctd_pkg::CHAR_PCT && !eos)
            begin
                pend = pctd_pkg::PEND_PCT;
            end
            else
            begin
                step_bytes.push_back(b);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void note_input(logic [7:0] b, logic eos);
            logic [4:0]      lo;
            logic [4:0]      hi;
            pctd_pkg::pend_t prev;
            decoded_beat_t   beat;
            lo = hex_digit(b);
            hi = hex_digit(held_digit);
            prev = pend;
            pend = pctd_pkg::PEND_NONE;
            step_bytes.delete();
            inputs_seen++;
            case (prev)
                pctd_pkg::PEND_PCT:
                begin
                    if (lo[4] && eos)
                    begin
                        step_bytes.push_back(pctd_pkg::CHAR_PCT);
                        step_bytes.push_back(b);
                    end
                    else if (lo[4])
                    begin
                        pend = pctd_pkg::PEND_HEX;
                        held_digit = b;
                    end
                    else
                    begin
                        step_bytes.push_back(pctd_pkg::CHAR_PCT);
                        take_plain(b, eos);
                    end
                end
                pctd_pkg::PEND_HEX:
                begin
                    if (lo[4])
                    begin
                        step_bytes.push_back({hi[3:0], lo[3:0]});
                        escapes_decoded++;
                    end
                    else
                    begin
                        step_bytes.push_back(pctd_pkg::CHAR_PCT);
                        step_bytes.push_back(held_digit);
                        take_plain(b, eos);
                    end
                end
                default:
                begin
                    take_plain(b, eos);
                end
            endcase
            if (pend != pctd_pkg::PEND_HEX || eos)
            begin
                held_digit = '0;
            end
            if (eos)
            begin
                pend = pctd_pkg::PEND_NONE;
                strings_seen++;
            end
            for (int i = 0; i < step_bytes.size(); i++)
            begin
                beat.data = step_bytes[i];
                beat.run_last = (i == step_bytes.size() - 1);
                beat.str_end = (i == step_bytes.size() - 1) && eos;
                expected_q.push_back(beat);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH after %0d checked bytes: %s", beats_checked, msg);
        endtask

        task check_result(logic [7:0] data, logic run_last, logic str_end);
            decoded_beat_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected output byte %02h", data));
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            if (data !== want.data)
            begin
                report($sformatf("out_byte %02h, expected %02h", data, want.data));
            end
            if (run_last !== want.run_last)
            begin
                report($sformatf("run_last %b, expected %b on byte %02h",
                                 run_last, want.run_last, want.data));
            end
            if (str_end !== want.str_end)
            begin
                report($sformatf("string_end %b, expected %b on byte %02h",
                                 str_end, want.str_end, want.data));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    decode_scoreboard sb;
    raw_item_t        stim_q[$];
    bit               steady = 1'b0;
    int               cycles = 0;

    percent_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tuser  (m_tuser),    // [0] run_last
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycles);
            $display("percent_decoder_unit verification failed");
            $finish;
        end
    end

    // An input and an output transaction at the same edge are handled in
    // that order, so a result is never checked before its input is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_input(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata, m_tuser, m_tlast);
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic add_bytes(input logic [7:0] bytes_in[$]);
        raw_item_t item;
        for (int i = 0; i < bytes_in.size(); i++)
        begin
            item.data = bytes_in[i];
            item.last = (i == bytes_in.size() - 1);
            stim_q.push_back(item);
        end
    endtask

    task automatic add_text(input string s);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++)
        begin
            chars.push_back(s[i]);
        end
        add_bytes(chars);
    endtask

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(21);
        if (r < 10)
        begin
            return pctd_pkg::CHAR_0 + 8'(r);
        end
        if (r < 16)
        begin
            return pctd_pkg::CHAR_UC_A + 8'(r - 10);
        end
        return pctd_pkg::CHAR_LC_A + 8'(r - 16);
    endfunction

    // Strings are mostly valid escapes with random digits, mixed with broken
    // escapes, lone percent signs and arbitrary bytes.
    task automatic add_random_strings(input int target);
        int         segs;
        int         kind;
        logic [7:0] str[$];
        while (stim_q.size() < target)
        begin
            str.delete();
            segs = $urandom_range(6, 1);
            repeat (segs)
            begin
                kind = $urandom_range(99);
                if (kind < 45)
                begin
                    str.push_back(pctd_pkg::CHAR_PCT);
                    str.push_back(random_hex_char());
                    str.push_back(random_hex_char());
                end
                else if (kind < 57)
                begin
                    str.push_back(pctd_pkg::CHAR_PCT);
                    if ($urandom_range(1))
                    begin
                        str.push_back(random_hex_char());
                    end
                    str.push_back(8'($urandom_range(255)));
                end
                else if (kind < 65)
                begin
                    str.push_back(pctd_pkg::CHAR_PCT);
                end
                else
                begin
                    str.push_back(8'($urandom_range(255)));
                end
            end
            add_bytes(str);
        end
    endtask

    // Once raised, s_tvalid stays high until the transaction is taken.
    task automatic drive_items();
        int idx;
        bit hold;
        idx = 0;
        hold = 1'b0;
        while (idx < stim_q.size())
        begin
            @(negedge clk);
            if (!hold)
            begin
                if (!steady && $urandom_range(99) < IDLE_PCT)
                begin
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= stim_q[idx].data;
                    s_tlast <= stim_q[idx].last;
                    hold = 1'b1;
                end
            end
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                idx++;
                hold = 1'b0;
                steady = (idx >= STEADY_FIRST) && (idx < STEADY_LAST);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] raw[$];
        int         directed_count;
        sb = new();
        add_text("%4a%FF");
        add_text("%00");
        add_text("%%4g");
        add_text("%");
        add_text("%A");
        add_text("%3%");
        add_text("%z");
        raw = '{8'h00, 8'hFF};
        add_bytes(raw);
        directed_count = stim_q.size();
        add_random_strings(directed_count + RANDOM_ITEMS);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        drive_items();
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Fed %0d bytes in %0d strings (%0d directed); checked %0d output bytes.",
                 sb.inputs_seen, sb.strings_seen, directed_count, sb.beats_checked);
        $display("Decoded %0d escapes; %0d mismatches.", sb.escapes_decoded, sb.errors);
        if (sb.errors == 0)
        begin
            $display("percent_decoder_unit verification clean");
        end
        else
        begin
            $display("percent_decoder_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
